// File: rtl/fpa_pkg.sv
// Shared types for the fixed-point arithmetic unit: operation codes,
// the request and response words, and the control bundle that travels with each stage.
// No dependencies.
package fpa_pkg;

    // Operation codes carried in the request word
    typedef enum logic [2:0] {
        OP_INT_TO_FIXED = 3'd0,
        OP_TO_INT_TRUNC = 3'd1,
        OP_TO_INT_ROUND = 3'd2,
        OP_ADD          = 3'd3,
        OP_SUB          = 3'd4,
        OP_MUL          = 3'd5,
        OP_DIV          = 3'd6
    } op_t;

    // Request word
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    // Response word
    typedef struct packed {
        logic signed [31:0] result;
        logic               divide_by_zero;
    } out_word_t;

    // Per-stage control that rides along with the data
    typedef struct packed {
        logic valid;
        logic is_mul;
        logic is_div;
        logic negate;
        logic div_zero;
    } ctl_t;

endpackage

// File: rtl/fpa_front.sv
// Front end of the arithmetic unit: two register stages that decode the word, compute the
// simple operations and the multiply, and prepare the magnitudes for the divider.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  fpa_pkg::in_word_t              in_word,
    output fpa_pkg::ctl_t                  ctl,
    output logic [31:0]                    res,
    output logic [32+FRACTION_BITS-1:0]    dq,
    output logic [31:0]                    dvs
);
    import fpa_pkg::*;

    localparam int DIV_BITS = 32 + FRACTION_BITS;
    localparam logic [32:0] SCALE_M1 = 33'((64'd1 << FRACTION_BITS) - 64'd1);
    localparam logic [32:0] HALF     = 33'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [32:0] HALF_M1  = 33'((64'd1 << (FRACTION_BITS - 1)) - 64'd1);
    localparam logic signed [63:0] SCALE_M1_W = (64'sd1 <<< FRACTION_BITS) - 64'sd1;

    // Stage A registers
    ctl_t                   ctl_a_reg, ctl_a_next;
    logic [31:0]            res_a_reg, res_a_next;
    logic signed [63:0]     prod_a_reg, prod_a_next;
    logic [DIV_BITS-1:0]    dq_a_reg, dq_a_next;
    logic [31:0]            dvs_a_reg, dvs_a_next;

    // Stage B registers
    ctl_t                   ctl_b_reg;
    logic [31:0]            res_b_reg, res_b_next;
    logic [DIV_BITS-1:0]    dq_b_reg;
    logic [31:0]            dvs_b_reg;

    logic [31:0]            a_u;
    logic [31:0]            b_u;
    logic [31:0]            a_mag;
    logic [31:0]            b_mag;
    logic [32:0]            bias;
    logic signed [32:0]     a_ext;
    logic signed [32:0]     conv_sum;
    logic signed [32:0]     conv_shift;
    logic [31:0]            shl;
    logic signed [63:0]     mul_sum;
    logic signed [63:0]     mul_shift;

    assign a_u   = in_word.operand_a;
    assign b_u   = in_word.operand_b;
    assign a_mag = a_u[31] ? (~a_u + 32'd1) : a_u;
    assign b_mag = b_u[31] ? (~b_u + 32'd1) : b_u;
    assign a_ext = $signed({a_u[31], a_u});
    assign shl   = a_u << FRACTION_BITS;

    // Pick the rounding offset so one add and an arithmetic shift cover both conversions
    always_comb
    begin
        bias = '0;
        if (op_t'(in_word.operation) == OP_TO_INT_ROUND)
        begin
            bias = a_u[31] ? HALF_M1 : HALF;
        end
        else if (a_u[31])
        begin
            bias = SCALE_M1;
        end
    end

    assign conv_sum   = a_ext + $signed(bias);
    assign conv_shift = conv_sum >>> FRACTION_BITS;

    // Decode the word and compute stage A results
    always_comb
    begin
        ctl_a_next          = '0;
        ctl_a_next.valid    = in_valid;
        res_a_next          = '0;
        prod_a_next         = $signed(in_word.operand_a) * $signed(in_word.operand_b);
        dq_a_next           = {a_mag, {FRACTION_BITS{1'b0}}};
        dvs_a_next          = b_mag;
        unique case (op_t'(in_word.operation))
            OP_INT_TO_FIXED: res_a_next = shl;
            OP_TO_INT_TRUNC: res_a_next = conv_shift[31:0];
            OP_TO_INT_ROUND: res_a_next = conv_shift[31:0];
            OP_ADD:          res_a_next = a_u + b_u;
            OP_SUB:          res_a_next = a_u - b_u;
            OP_MUL:          ctl_a_next.is_mul = 1'b1;
            OP_DIV:
            begin
                ctl_a_next.is_div   = 1'b1;
                ctl_a_next.negate   = a_u[31] ^ b_u[31];
                ctl_a_next.div_zero = (b_u == 32'd0);
            end
            default:         res_a_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_a_reg  <= res_a_next;
            prod_a_reg <= prod_a_next;
            dq_a_reg   <= dq_a_next;
            dvs_a_reg  <= dvs_a_next;
        end
    end

    // Scale the product down, truncating toward zero
    assign mul_sum   = prod_a_reg + (prod_a_reg[63] ? SCALE_M1_W : 64'sd0);
    assign mul_shift = mul_sum >>> FRACTION_BITS;
    assign res_b_next = ctl_a_reg.is_mul ? mul_shift[31:0] : res_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_b_reg <= res_b_next;
            dq_b_reg  <= dq_a_reg;
            dvs_b_reg <= dvs_a_reg;
        end
    end

    assign ctl = ctl_b_reg;
    assign res = res_b_reg;
    assign dq  = dq_b_reg;
    assign dvs = dvs_b_reg;

endmodule

// File: rtl/fpa_div_stage.sv
// One step of the unsigned restoring divider: produces one quotient bit per stage
// and carries the control bundle and side result along. Depends on fpa_pkg.
module fpa_div_stage #(
    parameter int DIV_BITS = 46
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  fpa_pkg::ctl_t         ctl_i,
    input  logic [31:0]           res_i,
    input  logic [31:0]           rem_i,
    input  logic [DIV_BITS-1:0]   dq_i,
    input  logic [31:0]           dvs_i,
    output fpa_pkg::ctl_t         ctl_o,
    output logic [31:0]           res_o,
    output logic [31:0]           rem_o,
    output logic [DIV_BITS-1:0]   dq_o,
    output logic [31:0]           dvs_o
);
    import fpa_pkg::*;

    ctl_t                   ctl_reg;
    logic [31:0]            res_reg;
    logic [31:0]            rem_reg, rem_next;
    logic [DIV_BITS-1:0]    dq_reg, dq_next;
    logic [31:0]            dvs_reg;

    logic [32:0]            trial;
    logic [32:0]            diff;
    logic                   fits;

    // Shift in the next dividend bit and try to subtract the divisor
    assign trial    = {rem_i, dq_i[DIV_BITS-1]};
    assign diff     = trial - {1'b0, dvs_i};
    assign fits     = (trial >= {1'b0, dvs_i});
    assign rem_next = fits ? diff[31:0] : trial[31:0];
    assign dq_next  = {dq_i[DIV_BITS-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_i;
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            dvs_reg <= dvs_i;
        end
    end

    assign ctl_o = ctl_reg;
    assign res_o = res_reg;
    assign rem_o = rem_reg;
    assign dq_o  = dq_reg;
    assign dvs_o = dvs_reg;

endmodule

// File: rtl/fpa_back.sv
// Output stage of the arithmetic unit: applies the quotient sign, forces the
// divide-by-zero result and holds the response word. Depends on fpa_pkg.
module fpa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fpa_pkg::ctl_t        ctl_i,
    input  logic [31:0]          res_i,
    input  logic [31:0]          quo_i,
    output logic                 out_valid,
    output fpa_pkg::out_word_t   out_word
);
    import fpa_pkg::*;

    logic       valid_reg;
    out_word_t  word_reg, word_next;

    // Select the final result and sign the quotient
    always_comb
    begin
        word_next                = '0;
        word_next.divide_by_zero = ctl_i.div_zero;
        if (ctl_i.is_div && !ctl_i.div_zero)
        begin
            word_next.result = ctl_i.negate ? (~quo_i + 32'd1) : quo_i;
        end
        else
        begin
            word_next.result = res_i;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/fixed_point_q17_14_alu.sv
// Signed fixed-point arithmetic unit, pipelined.
// Pipeline: two front stages, then a one-bit-per-stage divider of 32 + FRACTION_BITS
// stages, then one output stage; all operations share the same pipeline depth.
// Throughput: one word per cycle while res_stall does not hold the output word.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module fixed_point_q17_14_alu #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_stall,
    input  fpa_pkg::in_word_t    op_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output fpa_pkg::out_word_t   res_word
);
    import fpa_pkg::*;

    localparam int DIV_BITS = 32 + FRACTION_BITS;

    logic                   advance;
    ctl_t                   ctl_q [0:DIV_BITS];
    logic [31:0]            res_q [0:DIV_BITS];
    logic [31:0]            rem_q [0:DIV_BITS];
    logic [DIV_BITS-1:0]    dq_q  [0:DIV_BITS];
    logic [31:0]            dvs_q [0:DIV_BITS];

    // Advance the whole pipeline unless the held output word is stalled
    assign advance  = !res_valid || !res_stall;
    assign op_stall = !advance;

    fpa_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (op_valid),
        .in_word  (op_word),
        .ctl      (ctl_q[0]),
        .res      (res_q[0]),
        .dq       (dq_q[0]),
        .dvs      (dvs_q[0])
    );

    // Partial remainder starts empty
    assign rem_q[0] = '0;

    // Divider chain, one quotient bit per stage
    generate
        for (genvar i = 0; i < DIV_BITS; i++)
        begin : g_div
            fpa_div_stage #(
                .DIV_BITS (DIV_BITS)
            ) u_stage (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (advance),
                .ctl_i (ctl_q[i]),
                .res_i (res_q[i]),
                .rem_i (rem_q[i]),
                .dq_i  (dq_q[i]),
                .dvs_i (dvs_q[i]),
                .ctl_o (ctl_q[i+1]),
                .res_o (res_q[i+1]),
                .rem_o (rem_q[i+1]),
                .dq_o  (dq_q[i+1]),
                .dvs_o (dvs_q[i+1])
            );
        end
    endgenerate

    fpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .ctl_i     (ctl_q[DIV_BITS]),
        .res_i     (res_q[DIV_BITS]),
        .quo_i     (dq_q[DIV_BITS][31:0]),
        .out_valid (res_valid),
        .out_word  (res_word)
    );

endmodule
